// ----- rtl/union_find_terminal_join_assert.svh -----
// Assertion macros for the union-find joining engine
// Expects signals named clk and rst_n in the scope of each use
`ifndef UNION_FIND_TERMINAL_JOIN_ASSERT_SVH
`define UNION_FIND_TERMINAL_JOIN_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define UFTJ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define UFTJ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/uftj_pkg.sv -----
// Shared types and constants for the union-find joining engine
// No dependencies
`timescale 1ns / 1ps

package uftj_pkg;

  localparam int NODE_W    = 10;
  localparam int CNT_W     = 11;
  localparam int WEIGHT_W  = 32;
  localparam int WORD_W    = NODE_W + CNT_W;
  localparam int NODES_DEF = 1024;

  // item kinds
  localparam logic FUNC_MARK = 1'b0;
  localparam logic FUNC_EDGE = 1'b1;

  // result word handed from the sequencer to the output register
  typedef struct packed {
    logic                merged;
    logic                all_joined;
    logic [WEIGHT_W-1:0] answer;
  } res_t;

endpackage

// ----- rtl/uftj_in_if.sv -----
// Input channel: valid/ready handshake carrying one mark or edge word
// Depends on uftj_pkg
`timescale 1ns / 1ps

interface uftj_in_if;
  import uftj_pkg::*;

  logic                valid;
  logic                ready;
  logic                func;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic [WEIGHT_W-1:0] weight;

  modport source (output valid, output func, output node_a, output node_b,
                  output weight, input ready);
  modport sink   (input valid, input func, input node_a, input node_b,
                  input weight, output ready);
endinterface

// ----- rtl/uftj_out_if.sv -----
// Result channel: valid/ready handshake carrying one result word
// Depends on uftj_pkg
`timescale 1ns / 1ps

interface uftj_out_if;
  import uftj_pkg::*;

  logic                valid;
  logic                ready;
  logic                merged;
  logic                all_joined;
  logic [WEIGHT_W-1:0] answer;

  modport source (output valid, output merged, output all_joined, output answer,
                  input ready);
  modport sink   (input valid, input merged, input all_joined, input answer,
                  output ready);
endinterface

// ----- rtl/uftj_mem.sv -----
// Simple dual-port node memory: one write port, one registered read port
// No dependencies
`timescale 1ns / 1ps

module uftj_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int W     = 21
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/uftj_seq.sv -----
// Sequencer: clearing pass, root finds with path compression, linking
// Depends on uftj_pkg, uftj_in_if and the assertion macro header
`timescale 1ns / 1ps
`include "union_find_terminal_join_assert.svh"

module uftj_seq #(
  parameter int NODES = uftj_pkg::NODES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  uftj_in_if.sink                     in_chan,
  input  logic [uftj_pkg::CNT_W-1:0]  special_total,
  output logic                        res_valid,
  input  logic                        res_ready,
  output uftj_pkg::res_t              res,
  output logic                        mem_we,
  output logic [$clog2(NODES)-1:0]    mem_waddr,
  output logic [uftj_pkg::WORD_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(NODES)-1:0]    mem_raddr,
  input  logic [uftj_pkg::WORD_W-1:0] mem_rdata
);
  import uftj_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NODES - 1);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MARK  = 9'b000000100,
    S_FIND  = 9'b000001000,
    S_COMP  = 9'b000010000,
    S_NEXT  = 9'b000100000,
    S_LINKA = 9'b001000000,
    S_LINKB = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [NODE_W-1:0]   a_r, a_nxt;
  logic [NODE_W-1:0]   b_r, b_nxt;
  logic [WEIGHT_W-1:0] w_r, w_nxt;
  logic                phase_r, phase_nxt;
  logic [NODE_W-1:0]   start_r, start_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [NODE_W-1:0]   root_r, root_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [NODE_W-1:0]   ra_r, ra_nxt;
  logic [CNT_W-1:0]    cnta_r, cnta_nxt;
  logic                merged_r, merged_nxt;
  logic                done_r, done_nxt;
  logic [WEIGHT_W-1:0] answer_r, answer_nxt;

  logic [NODE_W-1:0]   rd_par;
  logic [CNT_W-1:0]    rd_cnt;
  logic [CNT_W-1:0]    sum;

  function automatic logic [AW-1:0] to_addr(input logic [NODE_W-1:0] id);
    return AW'(id);
  endfunction

  function automatic logic in_range(input logic [NODE_W-1:0] id);
    return (int'(id) < NODES);
  endfunction

  assign rd_par = mem_rdata[WORD_W-1:CNT_W];
  assign rd_cnt = mem_rdata[CNT_W-1:0];
  assign sum    = CNT_W'(cnta_r + cnt_r);

  // result word
  assign res_valid = (state_r == S_EMIT);
  assign res       = '{merged: merged_r, all_joined: done_r, answer: answer_r};

  // next-state and memory access logic
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    w_nxt         = w_r;
    phase_nxt     = phase_r;
    start_nxt     = start_r;
    cur_nxt       = cur_r;
    root_nxt      = root_r;
    cnt_nxt       = cnt_r;
    ra_nxt        = ra_r;
    cnta_nxt      = cnta_r;
    merged_nxt    = merged_r;
    done_nxt      = done_r;
    answer_nxt    = answer_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = '0;
    in_chan.ready = (state_r == S_IDLE);

    unique case (state_r)
      // every entry becomes its own root with no special vertices
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = {NODE_W'(clr_r), CNT_W'(0)};
        if (clr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      // take a word; start the first read unless it goes straight to the result
      S_IDLE: begin
        if (in_chan.valid) begin
          a_nxt      = in_chan.node_a;
          b_nxt      = in_chan.node_b;
          w_nxt      = in_chan.weight;
          merged_nxt = 1'b0;
          phase_nxt  = 1'b0;
          start_nxt  = in_chan.node_a;
          cur_nxt    = in_chan.node_a;
          if (in_chan.func == FUNC_MARK) begin
            if (in_range(in_chan.node_a)) begin
              mem_re    = 1'b1;
              mem_raddr = to_addr(in_chan.node_a);
              state_nxt = S_MARK;
            end else begin
              state_nxt = S_EMIT;
            end
          end else if (!done_r && in_range(in_chan.node_a) &&
                       in_range(in_chan.node_b)) begin
            mem_re    = 1'b1;
            mem_raddr = to_addr(in_chan.node_a);
            state_nxt = S_FIND;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end

      // mark only an untouched root
      S_MARK: begin
        if (rd_par == a_r && rd_cnt == '0) begin
          mem_we    = 1'b1;
          mem_waddr = to_addr(a_r);
          mem_wdata = {a_r, CNT_W'(1)};
        end
        state_nxt = S_EMIT;
      end

      // walk the parent chain up to the root
      S_FIND: begin
        if (rd_par == cur_r) begin
          root_nxt = cur_r;
          cnt_nxt  = rd_cnt;
          if (start_r == cur_r) begin
            state_nxt = S_NEXT;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = to_addr(start_r);
            cur_nxt   = start_r;
            state_nxt = S_COMP;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = to_addr(rd_par);
          cur_nxt   = rd_par;
        end
      end

      // second walk: point each node on the path at the root
      S_COMP: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(cur_r);
        mem_wdata = {root_r, rd_cnt};
        if (rd_par == root_r) begin
          state_nxt = S_NEXT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = to_addr(rd_par);
          cur_nxt   = rd_par;
        end
      end

      // gap after compression writes; start second find or decide link
      S_NEXT: begin
        if (!phase_r) begin
          ra_nxt    = root_r;
          cnta_nxt  = cnt_r;
          phase_nxt = 1'b1;
          start_nxt = b_r;
          cur_nxt   = b_r;
          mem_re    = 1'b1;
          mem_raddr = to_addr(b_r);
          state_nxt = S_FIND;
        end else if (ra_r != root_r) begin
          state_nxt = S_LINKA;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      // first root goes under the second, its count cleared
      S_LINKA: begin
        mem_we    = 1'b1;
        mem_waddr = to_addr(ra_r);
        mem_wdata = {root_r, CNT_W'(0)};
        state_nxt = S_LINKB;
      end

      // second root takes the sum; latch the answer when complete
      S_LINKB: begin
        mem_we     = 1'b1;
        mem_waddr  = to_addr(root_r);
        mem_wdata  = {root_r, sum};
        merged_nxt = 1'b1;
        if (sum == special_total) begin
          done_nxt   = 1'b1;
          answer_nxt = w_r;
        end
        state_nxt = S_EMIT;
      end

      // hand the result word over
      S_EMIT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      phase_r  <= 1'b0;
      merged_r <= 1'b0;
      done_r   <= 1'b0;
      answer_r <= '0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      phase_r  <= phase_nxt;
      merged_r <= merged_nxt;
      done_r   <= done_nxt;
      answer_r <= answer_nxt;
    end
  end

  // item and walk registers
  always_ff @(posedge clk) begin
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    w_r     <= w_nxt;
    start_r <= start_nxt;
    cur_r   <= cur_nxt;
    root_r  <= root_nxt;
    cnt_r   <= cnt_nxt;
    ra_r    <= ra_nxt;
    cnta_r  <= cnta_nxt;
  end

  // checks
  `UFTJ_ASSERT_IMP(a_no_rw_clash, mem_we && mem_re, mem_waddr != mem_raddr, "read and write to one entry in one cycle")
  `UFTJ_ASSERT_NXT(a_done_sticky, done_r, done_r, "joined flag dropped after latching")
  `UFTJ_ASSERT_IMP(a_link_distinct, state_r == S_LINKA, ra_r != root_r, "linking a root to itself")
  `UFTJ_ASSERT_IMP(a_raddr_range, mem_re, int'(mem_raddr) < NODES, "read beyond the node count")

endmodule

// ----- rtl/union_find_terminal_join.sv -----
// Top level of the union-find joining engine: config register, output register
// Depends on uftj_pkg, uftj_in_if, uftj_out_if, uftj_mem and uftj_seq
//
//   channel   dir   handshake       payload
//   in_chan   in    valid / ready   func, node_a, node_b, weight
//   out_chan  out   valid / ready   merged, all_joined, answer
//   cfg_*     in    cfg_we          cfg_wdata (special_total)
//
// A mark word reads its node and marks it if it is an untouched root. An edge walks
// each endpoint up to its root and back again to compress the path, both finds and
// their compression sharing the one read port of the node memory, and links the two
// roots when they differ; an edge after the answer has latched is answered without a
// find. After reset a clearing pass writes all NODES entries, one a cycle, with
// in_chan.ready low. A new word is taken while a result waits in the output register;
// a stalled result holds the sequencer only once its next word is done.
`timescale 1ns / 1ps

module union_find_terminal_join #(
  parameter int NODES = uftj_pkg::NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  uftj_in_if.sink                    in_chan,
  uftj_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [uftj_pkg::CNT_W-1:0] cfg_wdata
);
  import uftj_pkg::*;

  localparam int AW = $clog2(NODES);

  logic [CNT_W-1:0]  special_total_r;
  logic              res_valid;
  logic              res_ready;
  res_t              res;
  logic              out_valid_r;
  res_t              out_res_r;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      special_total_r <= '0;
    end else if (cfg_we) begin
      special_total_r <= cfg_wdata;
    end
  end

  uftj_seq #(.NODES(NODES)) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_chan       (in_chan),
    .special_total (special_total_r),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .mem_rdata     (mem_rdata)
  );

  uftj_mem #(.DEPTH(NODES), .AW(AW), .W(WORD_W)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register parts the sequencer from the result channel
  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.merged     = out_res_r.merged;
  assign out_chan.all_joined = out_res_r.all_joined;
  assign out_chan.answer     = out_res_r.answer;

endmodule
